// ----- hdl/hash_dedup_key_registry_defines.svh -----
// Assertion macros shared by the key registry RTL.
`ifndef HASH_DEDUP_KEY_REGISTRY_DEFINES_SVH
`define HASH_DEDUP_KEY_REGISTRY_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define HDKR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define HDKR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/hdkr_pkg.sv -----
// Types, constants and hash helpers for the key registry.
package hdkr_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int FIELD_BYTES = 96;
    localparam int KEY_FIELDS  = 5;

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int BYTE_CNT_W = $clog2(FIELD_BYTES);
    localparam int FIELD_NUM_W = (KEY_FIELDS > 1) ? $clog2(KEY_FIELDS) : 1;

    localparam logic [63:0] FNV_BASIS   = 64'd1469598103934665603;
    // prime = 2^40 + 0x1B3
    localparam logic [63:0] FNV_PRIME_LO = 64'h1B3;
    localparam logic [7:0]  EMPTY_CHAR  = 8'h3F;

    localparam logic FUNC_BYTE  = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_DUPLICATE = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
        logic       has_byte;
        logic       field_last;
    } req_t;

    typedef struct packed {
        logic [63:0] key_hash;
        status_t     status;
        logic [9:0]  slot_index;
        logic [10:0] entry_count;
    } rsp_t;

    // Multiply by the FNV prime, mod 2^64
    function automatic logic [63:0] fnv_mul(input logic [63:0] x);
        fnv_mul = (x << 40) + (x * FNV_PRIME_LO);
    endfunction

    localparam logic [63:0] EMPTY_HASH = fnv_mul(FNV_BASIS ^ {56'd0, EMPTY_CHAR});

endpackage

// ----- hdl/hash_dedup_key_registry.sv -----
// Top level: FNV-1a-style key hashing (non-standard offset basis) and dedup table of stored key hashes.
// Byte request: busy stays low. A field-closing request holds busy for the fold state.
// The key-closing request holds busy for the fold plus a table scan that ends at a match,
// after the last stored entry on insert, or at once when full; the scan reads one entry a cycle.
// Result strobe (done) rises in the cycle after the last busy cycle, for one cycle.
// Reset empties the table (count to zero) and drops any partial key; entries are not cleared.
`include "hash_dedup_key_registry_defines.svh"

module hash_dedup_key_registry (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  hdkr_pkg::req_t request,
    output logic          done,
    output hdkr_pkg::rsp_t result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FOLD,
        S_SEARCH
    } state_t;

    state_t state_reg, state_next;

    logic [63:0]                     field_hash_reg, field_hash_next;
    logic [63:0]                     combined_reg, combined_next;
    logic [hdkr_pkg::BYTE_CNT_W-1:0] bytes_reg, bytes_next;
    logic [hdkr_pkg::FIELD_NUM_W-1:0] field_num_reg, field_num_next;
    logic                            closed_reg, closed_next;
    logic [hdkr_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [hdkr_pkg::CNT_W-1:0]      rd_idx_reg, rd_idx_next;
    logic [hdkr_pkg::CNT_W-1:0]      cmp_idx_reg, cmp_idx_next;
    logic                            cmp_valid_reg, cmp_valid_next;
    logic                            done_reg, done_next;
    hdkr_pkg::rsp_t                  result_reg, result_next;

    // Key hash table and its registered read port
    logic [63:0] mem [hdkr_pkg::TABLE_DEPTH];
    logic [63:0] rdata_reg;

    logic        accept;
    logic        mem_re, mem_we;
    logic        match, more, full;
    logic [63:0] byte_hash;
    logic [63:0] fold_hash;

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;

    // Search compare and scan bounds
    assign match = cmp_valid_reg && (rdata_reg == combined_reg);
    assign more  = (rd_idx_reg < count_reg);
    assign full  = (count_reg >= hdkr_pkg::CNT_W'(hdkr_pkg::TABLE_DEPTH));

    assign mem_re = (state_reg == S_SEARCH) && !full && !match && more;
    assign mem_we = (state_reg == S_SEARCH) && !full && !match && !more;

    // Per-byte FNV-1a step and per-field fold
    assign byte_hash = hdkr_pkg::fnv_mul(field_hash_reg ^ {56'd0, request.data_byte});
    assign fold_hash = hdkr_pkg::fnv_mul(combined_reg)
                     + ((bytes_reg == '0) ? hdkr_pkg::EMPTY_HASH : field_hash_reg);

    // Next-state logic
    always_comb
    begin
        state_next      = state_reg;
        field_hash_next = field_hash_reg;
        combined_next   = combined_reg;
        bytes_next      = bytes_reg;
        field_num_next  = field_num_reg;
        closed_next     = closed_reg;
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        cmp_idx_next    = cmp_idx_reg;
        cmp_valid_next  = 1'b0;
        done_next       = 1'b0;
        result_next     = result_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (request.func == hdkr_pkg::FUNC_CLEAR)
                    begin
                        count_next      = '0;
                        field_hash_next = hdkr_pkg::FNV_BASIS;
                        bytes_next      = '0;
                        closed_next     = 1'b0;
                        combined_next   = '0;
                        field_num_next  = '0;
                    end
                    else
                    begin
                        if (request.has_byte && !closed_reg)
                        begin
                            if (request.data_byte == 8'd0)
                            begin
                                closed_next = 1'b1;
                            end
                            else if (bytes_reg <
                                     hdkr_pkg::BYTE_CNT_W'(hdkr_pkg::FIELD_BYTES - 1))
                            begin
                                field_hash_next = byte_hash;
                                bytes_next      = bytes_reg + 1'b1;
                            end
                        end
                        if (request.field_last)
                        begin
                            state_next = S_FOLD;
                        end
                    end
                end
            end

            S_FOLD:
            begin
                combined_next   = fold_hash;
                field_hash_next = hdkr_pkg::FNV_BASIS;
                bytes_next      = '0;
                closed_next     = 1'b0;
                if (field_num_reg ==
                    hdkr_pkg::FIELD_NUM_W'(hdkr_pkg::KEY_FIELDS - 1))
                begin
                    field_num_next = '0;
                    rd_idx_next    = '0;
                    state_next     = S_SEARCH;
                end
                else
                begin
                    field_num_next = field_num_reg + 1'b1;
                    state_next     = S_IDLE;
                end
            end

            S_SEARCH:
            begin
                result_next.key_hash = combined_reg;
                priority if (full)
                begin
                    result_next.status      = hdkr_pkg::ST_FULL;
                    result_next.slot_index  = '0;
                    result_next.entry_count = 11'(count_reg);
                    done_next               = 1'b1;
                    combined_next           = '0;
                    state_next              = S_IDLE;
                end
                else if (match)
                begin
                    result_next.status      = hdkr_pkg::ST_DUPLICATE;
                    result_next.slot_index  = 10'(cmp_idx_reg);
                    result_next.entry_count = 11'(count_reg);
                    done_next               = 1'b1;
                    combined_next           = '0;
                    state_next              = S_IDLE;
                end
                else if (more)
                begin
                    cmp_idx_next   = rd_idx_reg;
                    cmp_valid_next = 1'b1;
                    rd_idx_next    = rd_idx_reg + 1'b1;
                end
                else
                begin
                    count_next              = count_reg + 1'b1;
                    result_next.status      = hdkr_pkg::ST_INSERTED;
                    result_next.slot_index  = 10'(count_reg);
                    result_next.entry_count = 11'(count_reg + 1'b1);
                    done_next               = 1'b1;
                    combined_next           = '0;
                    state_next              = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            field_hash_reg <= hdkr_pkg::FNV_BASIS;
            combined_reg   <= '0;
            bytes_reg      <= '0;
            field_num_reg  <= '0;
            closed_reg     <= 1'b0;
            count_reg      <= '0;
            rd_idx_reg     <= '0;
            cmp_valid_reg  <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            field_hash_reg <= field_hash_next;
            combined_reg   <= combined_next;
            bytes_reg      <= bytes_next;
            field_num_reg  <= field_num_next;
            closed_reg     <= closed_next;
            count_reg      <= count_next;
            rd_idx_reg     <= rd_idx_next;
            cmp_valid_reg  <= cmp_valid_next;
            done_reg       <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= cmp_idx_next;
        result_reg  <= result_next;
    end

    // Table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[count_reg[hdkr_pkg::ADDR_W-1:0]] <= combined_reg;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[rd_idx_reg[hdkr_pkg::ADDR_W-1:0]];
        end
    end

    // Checks
    `HDKR_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1,
        count_reg <= hdkr_pkg::CNT_W'(hdkr_pkg::TABLE_DEPTH), "stored count beyond table depth")
    `HDKR_ASSERT_NOW(a_insert_slot, clk, rst_n,
        done && (result.status == hdkr_pkg::ST_INSERTED),
        result.entry_count == (11'(result.slot_index) + 11'd1), "inserted slot not last entry")
    `HDKR_ASSERT_NEXT(a_clear_empties, clk, rst_n,
        accept && (request.func == hdkr_pkg::FUNC_CLEAR),
        (count_reg == '0) && !busy, "clear did not empty table")
    `HDKR_ASSERT_NEXT(a_done_idle, clk, rst_n, done_next, !busy && done,
        "result not followed by idle")
    `HDKR_ASSERT_NOW(a_no_write_full, clk, rst_n, mem_we, !full && !mem_re,
        "table write while full or reading")

endmodule

// ----- verif/tb_hash_dedup_key_registry.sv -----
// Self-checking testbench for the FNV-1a-style key hash dedup registry.
`timescale 1ns / 1ps

module tb_hash_dedup_key_registry;

    localparam logic [63:0] KEY_PRIME = 64'd1099511628211;
    localparam logic [63:0] EMPTY_FIELD_HASH =
        (hdkr_pkg::FNV_BASIS ^ {56'd0, hdkr_pkg::EMPTY_CHAR}) * KEY_PRIME;
    // longest busy stretch is a full table scan plus a sender gap
    localparam int STALL_LIMIT  = 8000;
    localparam int DRAIN_CYCLES = 64;
    localparam int RAND_ITEMS   = 1000;
    localparam int POOL_SIZE    = 12;

    logic clk;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic done;
    hdkr_pkg::req_t request = '0;
    hdkr_pkg::rsp_t result;

    hash_dedup_key_registry uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    // 100 MHz clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // requests waiting to be sent, and key results the registry still owes
    hdkr_pkg::req_t pending_reqs[$];
    hdkr_pkg::rsp_t key_results[$];

    // shadow copy of the registry state
    logic [63:0] shadow_table [hdkr_pkg::TABLE_DEPTH];
    int unsigned shadow_count = 0;
    logic [63:0] field_acc = hdkr_pkg::FNV_BASIS;
    logic [63:0] key_fold = '0;
    int unsigned field_idx = 0;
    int unsigned field_len = 0;
    bit field_ended = 1'b0;

    int unsigned n_sent = 0;
    int unsigned n_accepted = 0;
    int unsigned n_inserted = 0;
    int unsigned n_dups = 0;
    int unsigned n_full = 0;
    int unsigned n_clears = 0;
    int unsigned fail_count = 0;
    int unsigned stall_cycles = 0;
    hdkr_pkg::rsp_t want;

    // Hash one accepted request into the shadow state; queue the key result if one is due
    task automatic register_request(input hdkr_pkg::req_t r);
        hdkr_pkg::rsp_t res;
        logic [63:0] fh;
        logic [63:0] h;
        int unsigned i;
        if (r.func == hdkr_pkg::FUNC_CLEAR)
        begin
            shadow_count = 0;
            field_acc = hdkr_pkg::FNV_BASIS;
            field_len = 0;
            field_ended = 1'b0;
            key_fold = '0;
            field_idx = 0;
            n_clears++;
            return;
        end
        // byte hashing: zero byte closes content, overlong bytes dropped
        if (r.has_byte && !field_ended)
        begin
            if (r.data_byte == 8'h00)
                field_ended = 1'b1;
            else if (field_len < hdkr_pkg::FIELD_BYTES - 1)
            begin
                field_acc = (field_acc ^ {56'd0, r.data_byte}) * KEY_PRIME;
                field_len++;
            end
        end
        if (!r.field_last)
            return;
        // fold the finished field; an empty one counts as "?"
        fh = (field_len == 0) ? EMPTY_FIELD_HASH : field_acc;
        key_fold = key_fold * KEY_PRIME + fh;
        field_idx++;
        field_acc = hdkr_pkg::FNV_BASIS;
        field_len = 0;
        field_ended = 1'b0;
        if (field_idx < hdkr_pkg::KEY_FIELDS)
            return;
        h = key_fold;
        key_fold = '0;
        field_idx = 0;
        // table lookup
        res.key_hash = h;
        if (shadow_count >= hdkr_pkg::TABLE_DEPTH)
        begin
            res.status = hdkr_pkg::ST_FULL;
            res.slot_index = '0;
            n_full++;
        end
        else
        begin
            res.status = hdkr_pkg::ST_INSERTED;
            res.slot_index = 10'(shadow_count);
            for (i = 0; i < shadow_count; i++)
            begin
                if (shadow_table[i] == h)
                begin
                    res.status = hdkr_pkg::ST_DUPLICATE;
                    res.slot_index = 10'(i);
                    break;
                end
            end
            if (res.status == hdkr_pkg::ST_INSERTED)
            begin
                shadow_table[shadow_count] = h;
                shadow_count++;
                n_inserted++;
            end
            else
                n_dups++;
        end
        res.entry_count = 11'(shadow_count);
        key_results.push_back(res);
    endtask

    task automatic flag_result(input string what, input hdkr_pkg::rsp_t exp_r,
                               input hdkr_pkg::rsp_t got);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("%0t %s: expected hash=%h st=%0d slot=%0d cnt=%0d",
                     $time, what, exp_r.key_hash, exp_r.status, exp_r.slot_index,
                     exp_r.entry_count);
            $display("    got hash=%h st=%0d slot=%0d cnt=%0d",
                     got.key_hash, got.status, got.slot_index, got.entry_count);
        end
    endtask

    // Driver: one request in flight, start held until accepted
    always @(posedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else
        begin
            if (start && !busy)
            begin
                register_request(request);
                n_accepted++;
            end
            if (!(start && busy))
            begin
                // random pauses, none in a long stretch of the run
                if (pending_reqs.size() != 0 &&
                    !($urandom_range(0, 99) < 22 && !(n_sent >= 400 && n_sent < 1400)))
                begin
                    start <= 1'b1;
                    request <= pending_reqs.pop_front();
                    n_sent++;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: every done strobe is checked against the oldest owed result
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (key_results.size() == 0)
                flag_result("unexpected result", '0, result);
            else
            begin
                want = key_results.pop_front();
                if (result.key_hash !== want.key_hash || result.status !== want.status ||
                    result.slot_index !== want.slot_index ||
                    result.entry_count !== want.entry_count)
                    flag_result("mismatch", want, result);
            end
        end
    end

    // Watchdog: too long with no request accepted and no result
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("FAIL hash_dedup_key_registry");
            $finish;
        end
    end

    task automatic push_item(input logic f, input logic [7:0] b, input logic hb,
                             input logic fl);
        hdkr_pkg::req_t r;
        r.func = f;
        r.data_byte = b;
        r.has_byte = hb;
        r.field_last = fl;
        pending_reqs.push_back(r);
    endtask

    // small deterministic generator so a key can be replayed from its seed
    function automatic int unsigned lcg(inout int unsigned s);
        s = s * 32'd1664525 + 32'd1013904223;
        return s >> 8;
    endfunction

    // Push one well-formed key of KEY_FIELDS fields built from a seed
    task automatic push_key(input int unsigned seed);
        int unsigned s;
        int unsigned mode;
        int unsigned nbytes;
        int unsigned k;
        int unsigned f;
        logic [7:0] b;
        bit tail;
        bit hb;
        s = seed;
        for (f = 0; f < hdkr_pkg::KEY_FIELDS; f++)
        begin
            mode = lcg(s) % 16;
            if (mode == 0)
                nbytes = 0;
            else if (mode == 1)
                nbytes = 95 + lcg(s) % 16;   // field at or over the stored-byte limit
            else
                nbytes = 1 + lcg(s) % 8;
            tail = (nbytes == 0) || (lcg(s) % 3 == 0);
            for (k = 0; k < nbytes; k++)
            begin
                if (mode == 2 && lcg(s) % 4 == 0)
                    b = 8'h00;
                else
                    b = 8'(1 + lcg(s) % 255);
                if (lcg(s) % 8 == 0)
                    push_item(hdkr_pkg::FUNC_BYTE, 8'(lcg(s)), 1'b0, 1'b0);
                push_item(hdkr_pkg::FUNC_BYTE, b, 1'b1, !tail && (k == nbytes - 1));
            end
            // separate closing request, with no byte or a zero byte
            if (tail)
            begin
                b = 8'(lcg(s));
                hb = (lcg(s) % 2 == 0);
                push_item(hdkr_pkg::FUNC_BYTE, hb ? 8'h00 : b, hb, 1'b1);
            end
        end
    endtask

    // Stimulus and end of run
    initial
    begin
        int unsigned key_pool[POOL_SIZE];
        int unsigned rand_keys;
        int unsigned base;
        int unsigned pick;
        int unsigned i;
        int unsigned f;

        // directed: empty fields, zero byte, ignored bytes, explicit "?", byte extremes
        push_item(hdkr_pkg::FUNC_BYTE, 8'hA5, 1'b0, 1'b1);
        push_item(hdkr_pkg::FUNC_BYTE, 8'hFF, 1'b1, 1'b0);
        push_item(hdkr_pkg::FUNC_BYTE, 8'h01, 1'b1, 1'b1);
        push_item(hdkr_pkg::FUNC_BYTE, 8'h00, 1'b1, 1'b0);
        push_item(hdkr_pkg::FUNC_BYTE, 8'h41, 1'b1, 1'b0);
        push_item(hdkr_pkg::FUNC_BYTE, 8'h00, 1'b0, 1'b1);
        push_item(hdkr_pkg::FUNC_BYTE, 8'h3F, 1'b1, 1'b1);
        push_item(hdkr_pkg::FUNC_BYTE, 8'h80, 1'b1, 1'b1);
        // same key spelled differently: duplicate
        push_item(hdkr_pkg::FUNC_BYTE, 8'h00, 1'b1, 1'b1);
        push_item(hdkr_pkg::FUNC_BYTE, 8'hFF, 1'b1, 1'b0);
        push_item(hdkr_pkg::FUNC_BYTE, 8'h01, 1'b1, 1'b1);
        push_item(hdkr_pkg::FUNC_BYTE, 8'h3F, 1'b1, 1'b1);
        push_item(hdkr_pkg::FUNC_BYTE, 8'h41, 1'b0, 1'b0);
        push_item(hdkr_pkg::FUNC_BYTE, 8'h00, 1'b1, 1'b1);
        push_item(hdkr_pkg::FUNC_BYTE, 8'h80, 1'b1, 1'b1);
        // partial key dropped by a clear
        push_item(hdkr_pkg::FUNC_BYTE, 8'h55, 1'b1, 1'b1);
        push_item(hdkr_pkg::FUNC_BYTE, 8'h66, 1'b1, 1'b0);
        push_item(hdkr_pkg::FUNC_CLEAR, 8'hFF, 1'b1, 1'b1);
        for (f = 0; f < hdkr_pkg::KEY_FIELDS; f++)
            push_item(hdkr_pkg::FUNC_BYTE, 8'h7E, 1'b1, 1'b1);

        // random: mostly keys (fresh or replayed), some noise and aborted keys
        for (i = 0; i < POOL_SIZE; i++)
            key_pool[i] = $urandom();
        base = pending_reqs.size();
        rand_keys = 0;
        while (pending_reqs.size() - base < RAND_ITEMS || rand_keys < 40)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
                push_item(hdkr_pkg::FUNC_CLEAR, 8'($urandom()), 1'($urandom()),
                          1'($urandom()));
            else if (pick < 8)
                push_item(hdkr_pkg::FUNC_BYTE, 8'($urandom()), 1'($urandom()),
                          1'($urandom()));
            else if (pick < 11)
            begin
                for (i = $urandom_range(1, 12); i > 0; i--)
                    push_item(hdkr_pkg::FUNC_BYTE, 8'($urandom()), 1'($urandom()),
                              1'($urandom()));
                push_item(hdkr_pkg::FUNC_CLEAR, 8'($urandom()), 1'($urandom()),
                          1'($urandom()));
            end
            else
            begin
                if (pick < 45)
                    push_key(key_pool[$urandom_range(0, POOL_SIZE - 1)]);
                else
                begin
                    i = $urandom_range(0, POOL_SIZE - 1);
                    key_pool[i] = $urandom();
                    push_key(key_pool[i]);
                end
                rand_keys++;
            end
        end

        // fill the table, then hit it while full with a stored and a new key
        push_item(hdkr_pkg::FUNC_CLEAR, 8'h00, 1'b0, 1'b0);
        for (i = 0; i <= hdkr_pkg::TABLE_DEPTH + 1; i++)
        begin
            if (i == hdkr_pkg::TABLE_DEPTH + 1)
            begin
                push_item(hdkr_pkg::FUNC_BYTE, 8'h01, 1'b1, 1'b1);
                push_item(hdkr_pkg::FUNC_BYTE, 8'h01, 1'b1, 1'b1);
                push_item(hdkr_pkg::FUNC_BYTE, 8'h5B, 1'b1, 1'b1);
            end
            else
            begin
                push_item(hdkr_pkg::FUNC_BYTE,
                          8'(1 + (i % hdkr_pkg::TABLE_DEPTH) % 32), 1'b1, 1'b1);
                push_item(hdkr_pkg::FUNC_BYTE,
                          8'(1 + (i % hdkr_pkg::TABLE_DEPTH) / 32), 1'b1, 1'b1);
                push_item(hdkr_pkg::FUNC_BYTE, 8'h5A, 1'b1, 1'b1);
            end
            for (f = 3; f < hdkr_pkg::KEY_FIELDS; f++)
                push_item(hdkr_pkg::FUNC_BYTE, 8'h5A, 1'b1, 1'b1);
        end
        // table usable again after a clear
        push_item(hdkr_pkg::FUNC_CLEAR, 8'h00, 1'b0, 1'b0);
        for (f = 0; f < hdkr_pkg::KEY_FIELDS; f++)
            push_item(hdkr_pkg::FUNC_BYTE, 8'h5A, 1'b1, 1'b1);
        push_item(hdkr_pkg::FUNC_CLEAR, 8'h00, 1'b0, 1'b0);

        // reset, then let the driver run
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_reqs.size() != 0 || start)
            @(posedge clk);
        while (key_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (key_results.size() != 0)
            fail_count++;

        $display("Sent %0d requests (%0d clears); keys: %0d inserted, %0d duplicate, %0d full",
                 n_accepted, n_clears, n_inserted, n_dups, n_full);
        $display("Failures: %0d", fail_count);
        if (fail_count == 0)
            $display("PASS hash_dedup_key_registry");
        else
            $display("FAIL hash_dedup_key_registry");
        $finish;
    end

endmodule
